>>> src/ipv4hp_pkg.sv
// ----------------------------------------------------------------------------
// ipv4hp_pkg: shared types and constants for the IPv4 header parser
// Verdict codes, link modes, header offsets and the link type decision.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4hp_pkg;

    localparam int DEF_LENGTH_BITS = 16;

    // Configuration register indexes.
    localparam logic REG_LINK_MODE = 1'b0;
    localparam logic REG_CSUM_EN   = 1'b1;

    localparam int CFG_DATA_W = 2;

    // Link header modes.
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_SHORT = 2'd1;
    localparam logic [1:0] MODE_ETH   = 2'd2;
    localparam logic [1:0] MODE_RAW   = 2'd3;

    localparam logic [1:0] LINK_MODE_RST = MODE_ETH;
    localparam logic       CSUM_EN_RST   = 1'b1;

    // Start of the IPv4 header for each kind of link header.
    localparam logic [4:0] OFS_NONE  = 5'd0;
    localparam logic [4:0] OFS_SHORT = 5'd4;
    localparam logic [4:0] OFS_ETH   = 5'd14;
    localparam logic [4:0] OFS_VLAN  = 5'd18;

    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [3:0]  IPV4_VERSION = 4'd4;
    localparam logic [3:0]  IPV4_IHL     = 4'd5;
    localparam logic [16:0] CSUM_GOOD    = 17'h0FFFF;
    localparam logic [7:0]  L4_MIN_BYTES = 8'd8;

    // Verdict codes.
    localparam logic [3:0] V_VALID      = 4'd0;
    localparam logic [3:0] V_NON_IP     = 4'd1;
    localparam logic [3:0] V_IP_SHORT   = 4'd2;
    localparam logic [3:0] V_OPTIONS    = 4'd3;
    localparam logic [3:0] V_VERSION    = 4'd4;
    localparam logic [3:0] V_CHECKSUM   = 4'd5;
    localparam logic [3:0] V_TCP_SHORT  = 4'd6;
    localparam logic [3:0] V_UDP_SHORT  = 4'd7;
    localparam logic [3:0] V_ICMP_SHORT = 4'd8;
    localparam logic [3:0] V_UNDEFINED  = 4'd9;

    localparam int VERDICT_W  = 4;
    localparam int OUT_DATA_W = 208;

    typedef struct packed {
        logic       not_ip;
        logic [4:0] offset;
    } link_t;

    // Header summary handed from the capture logic to the classifier.
    typedef struct packed {
        logic        link_not_ip;
        logic [4:0]  ip_offset;
        logic [3:0]  header_words;
        logic [3:0]  version;
        logic [16:0] ones_sum;
        logic [7:0]  protocol;
        logic [3:0]  tcp_words;
    } hdr_sum_t;

    // Resolve the link header from its two type bytes.
    function automatic link_t decide_link(input link_t cur, input logic [15:0] eth_type);
        link_t res;
        res = cur;
        if (cur.offset == OFS_ETH) begin
            if (eth_type == ETH_TYPE_VLAN) begin
                res.offset = OFS_VLAN;
            end else if (eth_type != ETH_TYPE_IPV4) begin
                res.not_ip = 1'b1;
            end
        end else if (cur.offset == OFS_SHORT) begin
            if (eth_type != ETH_TYPE_IPV4) begin
                res.not_ip = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/ipv4_header_parse_classify_top.sv
// ----------------------------------------------------------------------------
// ipv4_header_parse_classify_top: byte-stream IPv4 header parser
// Skips the link header, captures IPv4/TCP/UDP fields, checks the header
// checksum and gives one verdict request per frame.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle; each byte updates the capture registers
// in the cycle it is accepted, with one checksum add and fold on its path.
// The result request appears on the master side in the cycle after the
// byte marked tlast is accepted. Bytes that are not last are taken every cycle;
// a last byte waits only while an earlier result still sits in the output
// register and is not being taken. Reset is synchronous, active low: it clears
// all frame state and the output valid, and sets link mode 2, checksum on.
`default_nettype none

module ipv4_header_parse_classify_top #(
    parameter int LENGTH_BITS = ipv4hp_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port.
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_addr,
    input  wire logic [ipv4hp_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // Frame byte stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,   // [7:0] frame_byte
    input  wire logic                                s_tlast,   // frame_end
    // Result stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] src_address, [63:32] dst_address, [71:64] protocol,
    // [87:72] src_port, [103:88] dst_port, [119:104] ip_total_length,
    // [125:120] ip_header_bytes, [131:126] tcp_header_bytes,
    // [139:132] tcp_flag_bits, [171:140] tcp_sequence,
    // [203:172] tcp_acknowledge, [207:204] zero
    output logic [ipv4hp_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [ipv4hp_pkg::VERDICT_W-1:0]         m_tuser    // [3:0] verdict
);
    import ipv4hp_pkg::*;

    localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

    // Configuration registers.
    logic [1:0] link_mode_reg;
    logic       csum_en_reg;

    // Per-frame capture state.
    logic [LENGTH_BITS-1:0] pos_reg,    pos_next;
    link_t                  link_reg,   link_next;
    logic [7:0]             type_hi_reg, type_hi_next;
    logic [3:0]             hw_reg,     hw_next;
    logic [3:0]             ver_reg,    ver_next;
    logic [16:0]            sum_reg,    sum_next;
    logic [7:0]             proto_reg,  proto_next;
    logic [15:0]            len_reg,    len_next;
    logic [31:0]            src_reg,    src_next;
    logic [31:0]            dst_reg,    dst_next;
    logic [15:0]            sport_reg,  sport_next;
    logic [15:0]            dport_reg,  dport_next;
    logic [31:0]            seq_reg,    seq_next;
    logic [31:0]            ack_reg,    ack_next;
    logic [11:0]            tcpof_reg,  tcpof_next;

    // Output register.
    logic                       m_tvalid_reg;
    logic [OUT_DATA_W-1:0]      m_tdata_reg, m_tdata_next;
    logic [VERDICT_W-1:0]       m_tuser_reg;

    // Values after the current byte, before the end-of-frame clear.
    link_t                  link_cur;
    link_t                  link_step;
    link_t                  link_fin;
    logic [7:0]             type_hi_step;
    logic [3:0]             hw_step;
    logic [3:0]             ver_step;
    logic [16:0]            sum_step;
    logic [7:0]             proto_step;
    logic [15:0]            len_step;
    logic [31:0]            src_step;
    logic [31:0]            dst_step;
    logic [15:0]            sport_step;
    logic [15:0]            dport_step;
    logic [31:0]            seq_step;
    logic [31:0]            ack_step;
    logic [11:0]            tcpof_step;

    logic [LENGTH_BITS-1:0] ip_idx;
    logic                   in_ip;
    logic [6:0]             k_idx;
    logic [6:0]             j_idx;
    logic [5:0]             hbytes;
    logic [15:0]            addend;
    logic [17:0]            sum_wide;
    logic                   type_hi_hit;
    logic                   type_lo_hit;
    logic [LENGTH_BITS-1:0] captured;
    logic [VERDICT_W-1:0]   verdict;
    hdr_sum_t               summary;
    logic                   in_acc;
    logic                   frame_done;
    logic                   is_tcp;

    assign in_acc     = s_tvalid && s_tready;
    assign frame_done = in_acc && s_tlast;

    // A last byte needs the output register; other bytes never do.
    assign s_tready = !m_tvalid_reg || m_tready || !s_tlast;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_mode_reg <= LINK_MODE_RST;
            csum_en_reg   <= CSUM_EN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LINK_MODE: link_mode_reg <= cfg_wr_data[1:0];
                REG_CSUM_EN:   csum_en_reg   <= cfg_wr_data[0];
                default:       ;
            endcase
        end
    end

    // The link mode is sampled on the first byte of each frame.
    always_comb begin
        link_cur = link_reg;
        if (pos_reg == '0) begin
            unique case (link_mode_reg)
                MODE_SHORT: link_cur.offset = OFS_SHORT;
                MODE_ETH:   link_cur.offset = OFS_ETH;
                default:    link_cur.offset = OFS_NONE;
            endcase
            link_cur.not_ip = (link_mode_reg == MODE_RAW);
        end
    end

    assign type_hi_hit = (link_cur.offset == OFS_SHORT && pos_reg == LENGTH_BITS'(2)) ||
                         (link_cur.offset == OFS_ETH   && pos_reg == LENGTH_BITS'(12));
    assign type_lo_hit = (link_cur.offset == OFS_SHORT && pos_reg == LENGTH_BITS'(3)) ||
                         (link_cur.offset == OFS_ETH   && pos_reg == LENGTH_BITS'(13));

    // Position within the IPv4 header region; only the first 128 bytes matter.
    assign ip_idx = pos_reg - LENGTH_BITS'(link_cur.offset);
    assign in_ip  = (pos_reg >= LENGTH_BITS'(link_cur.offset)) &&
                    (ip_idx[LENGTH_BITS-1:7] == '0);
    assign k_idx  = ip_idx[6:0];

    // IHL of this byte counts as soon as the first header byte arrives.
    assign hw_step  = (in_ip && !type_lo_hit && k_idx == 7'd0) ? s_tdata[3:0] : hw_reg;
    assign hbytes   = {hw_step, 2'b00};
    assign j_idx    = k_idx - {1'b0, hbytes};
    assign addend   = k_idx[0] ? {8'h00, s_tdata} : {s_tdata, 8'h00};
    assign sum_wide = {1'b0, sum_reg} + {2'b00, addend};

    always_comb begin
        link_step    = link_cur;
        type_hi_step = type_hi_hit ? s_tdata : type_hi_reg;
        ver_step     = ver_reg;
        sum_step     = sum_reg;
        proto_step   = proto_reg;
        len_step     = len_reg;
        src_step     = src_reg;
        dst_step     = dst_reg;
        sport_step   = sport_reg;
        dport_step   = dport_reg;
        seq_step     = seq_reg;
        ack_step     = ack_reg;
        tcpof_step   = tcpof_reg;

        if (type_lo_hit) begin
            link_step = decide_link(link_cur, {type_hi_reg, s_tdata});
        end else if (in_ip) begin
            if (k_idx == 7'd0) begin
                ver_step = s_tdata[7:4];
            end
            if (k_idx == 7'd2 || k_idx == 7'd3) begin
                len_step = {len_reg[7:0], s_tdata};
            end
            if (k_idx == 7'd9) begin
                proto_step = s_tdata;
            end
            if (k_idx >= 7'd12 && k_idx < 7'd16) begin
                src_step = {src_reg[23:0], s_tdata};
            end
            if (k_idx >= 7'd16 && k_idx < 7'd20) begin
                dst_step = {dst_reg[23:0], s_tdata};
            end
            if (k_idx < {1'b0, hbytes}) begin
                // Add the byte in its half of the 16-bit word, then fold the carry.
                sum_step = {1'b0, sum_wide[15:0]} + {15'd0, sum_wide[17:16]};
            end else begin
                if (j_idx < 7'd2) begin
                    sport_step = {sport_reg[7:0], s_tdata};
                end else if (j_idx < 7'd4) begin
                    dport_step = {dport_reg[7:0], s_tdata};
                end else if (j_idx < 7'd8) begin
                    seq_step = {seq_reg[23:0], s_tdata};
                end else if (j_idx < 7'd12) begin
                    ack_step = {ack_reg[23:0], s_tdata};
                end else if (j_idx == 7'd12) begin
                    tcpof_step = {s_tdata[7:4], tcpof_reg[7:0]};
                end else if (j_idx == 7'd13) begin
                    tcpof_step = {tcpof_reg[11:8], s_tdata};
                end
            end
        end
    end

    // Frame end: a link header cut short decides its type with a zero low byte.
    assign captured = (pos_reg != POS_MAX) ? pos_reg + LENGTH_BITS'(1) : POS_MAX;

    always_comb begin
        link_fin = link_step;
        if ((link_step.offset == OFS_SHORT && captured < LENGTH_BITS'(4)) ||
            (link_step.offset == OFS_ETH   && captured < LENGTH_BITS'(14))) begin
            link_fin = decide_link(link_step, {type_hi_step, 8'h00});
        end
    end

    assign summary.link_not_ip  = link_fin.not_ip;
    assign summary.ip_offset    = link_fin.offset;
    assign summary.header_words = hw_step;
    assign summary.version      = ver_step;
    assign summary.ones_sum     = sum_step;
    assign summary.protocol     = proto_step;
    assign summary.tcp_words    = tcpof_step[11:8];

    ipv4hp_classify #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_classify (
        .summary  (summary),
        .captured (captured),
        .csum_en  (csum_en_reg),
        .verdict  (verdict)
    );

    // Result payload: all zero unless the packet is valid; TCP fields only for TCP.
    assign is_tcp = (proto_step == PROTO_TCP);

    always_comb begin
        m_tdata_next = '0;
        if (verdict == V_VALID) begin
            m_tdata_next[31:0]    = src_step;
            m_tdata_next[63:32]   = dst_step;
            m_tdata_next[71:64]   = proto_step;
            m_tdata_next[87:72]   = sport_step;
            m_tdata_next[103:88]  = dport_step;
            m_tdata_next[119:104] = len_step;
            m_tdata_next[125:120] = hbytes;
            if (is_tcp) begin
                m_tdata_next[131:126] = {tcpof_step[11:8], 2'b00};
                m_tdata_next[139:132] = tcpof_step[7:0];
                m_tdata_next[171:140] = seq_step;
                m_tdata_next[203:172] = ack_step;
            end
        end
    end

    // Next frame state: everything clears after the last byte.
    always_comb begin
        if (s_tlast) begin
            pos_next     = '0;
            link_next    = '0;
            type_hi_next = '0;
            hw_next      = '0;
            ver_next     = '0;
            sum_next     = '0;
            proto_next   = '0;
            len_next     = '0;
            src_next     = '0;
            dst_next     = '0;
            sport_next   = '0;
            dport_next   = '0;
            seq_next     = '0;
            ack_next     = '0;
            tcpof_next   = '0;
        end else begin
            pos_next     = (pos_reg != POS_MAX) ? pos_reg + LENGTH_BITS'(1) : POS_MAX;
            link_next    = link_step;
            type_hi_next = type_hi_step;
            hw_next      = hw_step;
            ver_next     = ver_step;
            sum_next     = sum_step;
            proto_next   = proto_step;
            len_next     = len_step;
            src_next     = src_step;
            dst_next     = dst_step;
            sport_next   = sport_step;
            dport_next   = dport_step;
            seq_next     = seq_step;
            ack_next     = ack_step;
            tcpof_next   = tcpof_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            link_reg    <= '0;
            type_hi_reg <= '0;
            hw_reg      <= '0;
            ver_reg     <= '0;
            sum_reg     <= '0;
            proto_reg   <= '0;
            len_reg     <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
            sport_reg   <= '0;
            dport_reg   <= '0;
            seq_reg     <= '0;
            ack_reg     <= '0;
            tcpof_reg   <= '0;
        end else if (in_acc) begin
            pos_reg     <= pos_next;
            link_reg    <= link_next;
            type_hi_reg <= type_hi_next;
            hw_reg      <= hw_next;
            ver_reg     <= ver_next;
            sum_reg     <= sum_next;
            proto_reg   <= proto_next;
            len_reg     <= len_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            sport_reg   <= sport_next;
            dport_reg   <= dport_next;
            seq_reg     <= seq_next;
            ack_reg     <= ack_next;
            tcpof_reg   <= tcpof_next;
        end
    end

    // Output register: loaded on a last byte, released when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (frame_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= verdict;
        end
    end

    // A result request only ever follows an accepted last byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result appeared without a frame end");

    // Every accepted last byte leaves a result waiting in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("frame end lost its result");

    // Any verdict other than valid carries an all-zero payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != V_VALID) |-> (m_tdata == '0))
        else $error("payload not cleared for a rejected frame");

    // The frame state restarts after each frame end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (pos_reg == '0 && sum_reg == '0))
        else $error("frame state not cleared after frame end");

endmodule

`default_nettype wire

>>> src/ipv4hp_classify.sv
// ----------------------------------------------------------------------------
// ipv4hp_classify: end-of-frame verdict
// Applies the header checks in override order to the captured summary.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4hp_classify #(
    parameter int LENGTH_BITS = ipv4hp_pkg::DEF_LENGTH_BITS
) (
    input  wire ipv4hp_pkg::hdr_sum_t       summary,
    input  wire logic [LENGTH_BITS-1:0]     captured,
    input  wire logic                       csum_en,
    output logic [ipv4hp_pkg::VERDICT_W-1:0] verdict
);
    import ipv4hp_pkg::*;

    logic [7:0] thr_ip;
    logic [7:0] thr_tcp;
    logic [7:0] thr_l4;

    // Largest threshold is 18 + 60 + 60, so eight bits are enough.
    assign thr_ip  = {3'b000, summary.ip_offset} + {2'b00, summary.header_words, 2'b00};
    assign thr_tcp = thr_ip + {2'b00, summary.tcp_words, 2'b00};
    assign thr_l4  = thr_ip + L4_MIN_BYTES;

    always_comb begin
        verdict = V_UNDEFINED;
        if (summary.link_not_ip) begin
            verdict = V_NON_IP;
        end
        if (captured < LENGTH_BITS'(thr_ip)) begin
            verdict = V_IP_SHORT;
        end
        if (summary.header_words != IPV4_IHL) begin
            verdict = V_OPTIONS;
        end
        if (summary.version != IPV4_VERSION) begin
            verdict = V_VERSION;
        end
        if (csum_en && summary.ones_sum != CSUM_GOOD) begin
            verdict = V_CHECKSUM;
        end
        if (summary.protocol == PROTO_TCP) begin
            if (captured < LENGTH_BITS'(thr_tcp)) begin
                verdict = V_TCP_SHORT;
            end else if (verdict == V_UNDEFINED) begin
                verdict = V_VALID;
            end
        end else if (summary.protocol == PROTO_UDP) begin
            if (captured < LENGTH_BITS'(thr_l4)) begin
                verdict = V_UDP_SHORT;
            end else if (verdict == V_UNDEFINED) begin
                verdict = V_VALID;
            end
        end else if (summary.protocol == PROTO_ICMP) begin
            if (captured < LENGTH_BITS'(thr_l4)) begin
                verdict = V_ICMP_SHORT;
            end
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the IPv4 header parser and classifier
// Builds captured frames (Ethernet, VLAN, four-byte and bare IPv4 headers
// carrying TCP, UDP, ICMP or other payloads), streams them byte by byte with
// random gaps and back-pressure, predicts the per-frame verdict request in a
// behavioral parser and compares every field of every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import ipv4hp_pkg::*;

    // The run is ended here if the block stops making progress.
    localparam int CYCLE_LIMIT = 1_000_000;

    // Frame position counter of the block saturates at this value.
    localparam int POS_MAX = (1 << DEF_LENGTH_BITS) - 1;

    // Random traffic stops once this many bytes and frames have been sent.
    localparam int RANDOM_BYTES  = 1150;
    localparam int RANDOM_FRAMES = 40;

    // Link header kinds used when building a frame.
    localparam int LINK_IP    = 0;
    localparam int LINK_VLAN  = 1;
    localparam int LINK_OTHER = 2;

    // One verdict request as it is expected on the master side.
    typedef struct packed {
        logic [3:0]  verdict;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] ip_total_length;
        logic [5:0]  ip_header_bytes;
        logic [5:0]  tcp_header_bytes;
        logic [7:0]  tcp_flag_bits;
        logic [31:0] tcp_sequence;
        logic [31:0] tcp_acknowledge;
    } hdr_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic                  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [VERDICT_W-1:0]  m_tuser;

    ipv4_header_parse_classify_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Clock, cycle guard.
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Behavioral parser. It holds its own copy of the two registers and of
    // the per-frame capture state, and turns each accepted byte into the
    // expected verdict request when the byte closes a frame.
    // ------------------------------------------------------------------------
    logic [1:0]  mode_cfg;
    bit          csum_cfg;

    int          pos_cnt;
    logic [4:0]  ip_ofs;
    bit          link_bad;
    logic [7:0]  type_hi;
    logic [3:0]  ihl_q;
    logic [3:0]  ver_q;
    logic [16:0] csum_acc;
    logic [7:0]  proto_q;
    logic [15:0] totlen_q;
    logic [31:0] addr_q [2];
    logic [15:0] port_q [2];
    logic [31:0] tcpnum_q [2];
    logic [11:0] tcp_off_flags;

    // Verdict requests predicted but not yet seen on the master side.
    hdr_result_t awaited_headers [$];

    int err_count = 0;

    function automatic void clear_parse_state();
        pos_cnt       = 0;
        ip_ofs        = OFS_NONE;
        link_bad      = 1'b0;
        type_hi       = '0;
        ihl_q         = '0;
        ver_q         = '0;
        csum_acc      = '0;
        proto_q       = '0;
        totlen_q      = '0;
        addr_q[0]     = '0;
        addr_q[1]     = '0;
        port_q[0]     = '0;
        port_q[1]     = '0;
        tcpnum_q[0]   = '0;
        tcpnum_q[1]   = '0;
        tcp_off_flags = '0;
    endfunction

    // Link type decision: Ethernet may turn into VLAN, anything but IPv4
    // marks the frame as non-IP.
    function automatic void resolve_link(logic [15:0] etype);
        if (ip_ofs == OFS_ETH) begin
            if (etype == ETH_TYPE_VLAN) begin
                ip_ofs = OFS_VLAN;
            end else if (etype != ETH_TYPE_IPV4) begin
                link_bad = 1'b1;
            end
        end else if (ip_ofs == OFS_SHORT) begin
            if (etype != ETH_TYPE_IPV4) begin
                link_bad = 1'b1;
            end
        end
    endfunction

    // Byte k of the IPv4 header and whatever follows it.
    function automatic void absorb_ip_byte(int k, logic [7:0] b);
        int hb;
        int j;
        int s;
        if (k == 0) begin
            ver_q = b[7:4];
            ihl_q = b[3:0];
        end
        if (k == 2 || k == 3) totlen_q = {totlen_q[7:0], b};
        if (k == 9) proto_q = b;
        if (k >= 12 && k < 16) addr_q[0] = {addr_q[0][23:0], b};
        if (k >= 16 && k < 20) addr_q[1] = {addr_q[1][23:0], b};
        hb = int'(ihl_q) * 4;
        if (k < hb) begin
            // Even bytes are the high half of a header word.
            s = int'(csum_acc) + ((k % 2 == 1) ? int'(b) : int'(b) * 256);
            s = (s & 'hFFFF) + (s >> 16);
            csum_acc = s[16:0];
        end else begin
            j = k - hb;
            if (j < 2) begin
                port_q[0] = {port_q[0][7:0], b};
            end else if (j < 4) begin
                port_q[1] = {port_q[1][7:0], b};
            end else if (j < 8) begin
                tcpnum_q[0] = {tcpnum_q[0][23:0], b};
            end else if (j < 12) begin
                tcpnum_q[1] = {tcpnum_q[1][23:0], b};
            end else if (j == 12) begin
                tcp_off_flags[11:8] = b[7:4];
            end else if (j == 13) begin
                tcp_off_flags[7:0] = b;
            end
        end
    endfunction

    function automatic void predict_frame_byte(logic [7:0] b, bit last);
        int          cap;
        int          hb;
        int          off;
        int          ofs;
        logic [3:0]  v;
        hdr_result_t r;
        // The link mode is latched on the first byte of every frame.
        if (pos_cnt == 0) begin
            case (mode_cfg)
                MODE_SHORT: ip_ofs = OFS_SHORT;
                MODE_ETH:   ip_ofs = OFS_ETH;
                default:    ip_ofs = OFS_NONE;
            endcase
            link_bad = (mode_cfg == MODE_RAW);
        end
        if ((ip_ofs == OFS_SHORT && pos_cnt == 2) || (ip_ofs == OFS_ETH && pos_cnt == 12))
            type_hi = b;
        if ((ip_ofs == OFS_SHORT && pos_cnt == 3) || (ip_ofs == OFS_ETH && pos_cnt == 13))
            resolve_link({type_hi, b});
        else if (pos_cnt >= int'(ip_ofs) && pos_cnt - int'(ip_ofs) < 128)
            absorb_ip_byte(pos_cnt - int'(ip_ofs), b);

        if (!last) begin
            if (pos_cnt < POS_MAX) pos_cnt++;
            return;
        end

        cap = (pos_cnt < POS_MAX) ? pos_cnt + 1 : POS_MAX;
        // A type that never fully arrived reads its missing bytes as zero.
        if ((ip_ofs == OFS_SHORT && cap < 4) || (ip_ofs == OFS_ETH && cap < 14))
            resolve_link({type_hi, 8'h00});

        ofs = int'(ip_ofs);
        hb  = int'(ihl_q) * 4;
        off = int'(tcp_off_flags[11:8]) * 4;

        // Later checks override earlier ones.
        v = V_UNDEFINED;
        if (link_bad) v = V_NON_IP;
        if (cap < ofs + hb) v = V_IP_SHORT;
        if (ihl_q != IPV4_IHL) v = V_OPTIONS;
        if (ver_q != IPV4_VERSION) v = V_VERSION;
        if (csum_cfg && csum_acc != CSUM_GOOD) v = V_CHECKSUM;
        if (proto_q == PROTO_TCP) begin
            if (cap < ofs + hb + off) v = V_TCP_SHORT;
            else if (v == V_UNDEFINED) v = V_VALID;
        end else if (proto_q == PROTO_UDP) begin
            if (cap < ofs + hb + 8) v = V_UDP_SHORT;
            else if (v == V_UNDEFINED) v = V_VALID;
        end else if (proto_q == PROTO_ICMP) begin
            if (cap < ofs + hb + 8) v = V_ICMP_SHORT;
        end

        r = '0;
        r.verdict = v;
        if (v == V_VALID) begin
            r.src_address     = addr_q[0];
            r.dst_address     = addr_q[1];
            r.protocol        = proto_q;
            r.src_port        = port_q[0];
            r.dst_port        = port_q[1];
            r.ip_total_length = totlen_q;
            r.ip_header_bytes = 6'(hb);
            if (proto_q == PROTO_TCP) begin
                r.tcp_header_bytes = 6'(off);
                r.tcp_flag_bits    = tcp_off_flags[7:0];
                r.tcp_sequence     = tcpnum_q[0];
                r.tcp_acknowledge  = tcpnum_q[1];
            end
        end
        awaited_headers.push_back(r);
        clear_parse_state();
    endfunction

    // ------------------------------------------------------------------------
    // Result side: a checker at the rising edge and a ready driver at the
    // falling edge. After each accepted request the receiver may hold ready
    // low; every 16 results it decides whether to stall at all, so that long
    // stretches without back-pressure also occur.
    // ------------------------------------------------------------------------
    int          hold_left   = 0;
    int          result_seen = 0;
    bit          stall_on    = 1'b1;
    hdr_result_t want_r;

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_headers.size() == 0) begin
                $error("verdict request %0d arrived with no frame outstanding", m_tuser);
                err_count++;
            end else begin
                want_r = awaited_headers.pop_front();
                check_field("verdict",          want_r.verdict,          m_tuser);
                check_field("src_address",      want_r.src_address,      m_tdata[31:0]);
                check_field("dst_address",      want_r.dst_address,      m_tdata[63:32]);
                check_field("protocol",         want_r.protocol,         m_tdata[71:64]);
                check_field("src_port",         want_r.src_port,         m_tdata[87:72]);
                check_field("dst_port",         want_r.dst_port,         m_tdata[103:88]);
                check_field("ip_total_length",  want_r.ip_total_length,  m_tdata[119:104]);
                check_field("ip_header_bytes",  want_r.ip_header_bytes,  m_tdata[125:120]);
                check_field("tcp_header_bytes", want_r.tcp_header_bytes, m_tdata[131:126]);
                check_field("tcp_flag_bits",    want_r.tcp_flag_bits,    m_tdata[139:132]);
                check_field("tcp_sequence",     want_r.tcp_sequence,     m_tdata[171:140]);
                check_field("tcp_acknowledge",  want_r.tcp_acknowledge,  m_tdata[203:172]);
            end
            result_seen++;
            if (result_seen % 16 == 0) stall_on = ($urandom_range(0, 2) != 0);
            hold_left = stall_on ? $urandom_range(0, 10) : 0;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Frame side.
    // ------------------------------------------------------------------------
    logic [7:0] frame_buf [$];
    bit         gaps_allowed = 1'b1;
    bit         gap_on       = 1'b1;
    int         random_bytes_sent = 0;

    // Send one frame byte: wait a random gap, present it, and hold it until
    // the block takes it. Valid stays high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input bit last);
        int gap;
        gap = (gaps_allowed && gap_on) ? $urandom_range(0, 10) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_frame_byte(b, last);
    endtask

    task automatic send_frame();
        int i;
        gap_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < frame_buf.size(); i++) begin
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        end
    endtask

    // Drop valid and wait until every verdict request has been taken, then
    // let the output register settle.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (awaited_headers.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Registers are written only while the block is idle.
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        if (idx == REG_LINK_MODE) mode_cfg = val;
        else csum_cfg = val[0];
    endtask

    // Build a frame in frame_buf. link_kind picks the type field, ihl and
    // ver go into the first IP byte, csum_ok decides whether the header
    // checksum is correct, and keep truncates the capture (0 keeps all).
    task automatic build_frame(input logic [1:0] mode, input int link_kind,
                               input logic [3:0] ver, input logic [3:0] ihl,
                               input logic [7:0] proto, input bit csum_ok, input int keep);
        int          ip_at;
        int          hl;
        int          l4_at;
        int          l4_len;
        int          tcp_words;
        int          i;
        int          sum;
        logic [15:0] csum;
        frame_buf.delete();
        if (mode == MODE_ETH) begin
            repeat (12) frame_buf.push_back(8'($urandom));
            if (link_kind == LINK_VLAN) begin
                frame_buf.push_back(ETH_TYPE_VLAN[15:8]);
                frame_buf.push_back(ETH_TYPE_VLAN[7:0]);
                repeat (2) frame_buf.push_back(8'($urandom));
            end
        end else if (mode == MODE_SHORT) begin
            repeat (2) frame_buf.push_back(8'($urandom));
        end
        if (mode == MODE_ETH || mode == MODE_SHORT) begin
            if (link_kind == LINK_OTHER) begin
                repeat (2) frame_buf.push_back(8'($urandom));
            end else begin
                frame_buf.push_back(ETH_TYPE_IPV4[15:8]);
                frame_buf.push_back(ETH_TYPE_IPV4[7:0]);
            end
        end

        // IPv4 header with the checksum slot zero for now.
        ip_at = frame_buf.size();
        hl    = int'(ihl) * 4;
        frame_buf.push_back({ver, ihl});
        repeat (7) frame_buf.push_back(8'($urandom));
        frame_buf.push_back(proto);
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'h00);
        repeat (8) frame_buf.push_back(8'($urandom));
        while (frame_buf.size() - ip_at < hl) frame_buf.push_back(8'($urandom));
        // The block sums only the first IHL words, so the checksum covers those.
        if (hl >= 12) begin
            sum = 0;
            for (i = 0; i < hl; i += 2) sum += {frame_buf[ip_at + i], frame_buf[ip_at + i + 1]};
            sum = (sum & 'hFFFF) + (sum >> 16);
            sum = (sum & 'hFFFF) + (sum >> 16);
            csum = ~sum[15:0];
            if (!csum_ok) csum ^= 16'($urandom_range(1, 65535));
            frame_buf[ip_at + 10] = csum[15:8];
            frame_buf[ip_at + 11] = csum[7:0];
        end

        // Layer-four header.
        l4_at = frame_buf.size();
        if (proto == PROTO_TCP) begin
            tcp_words = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
            l4_len    = (tcp_words * 4 > 14) ? tcp_words * 4 : 14;
            repeat (12) frame_buf.push_back(8'($urandom));
            frame_buf.push_back({4'(tcp_words), 4'($urandom)});
            frame_buf.push_back(8'($urandom));
            while (frame_buf.size() - l4_at < l4_len) frame_buf.push_back(8'($urandom));
        end else if (proto == PROTO_UDP || proto == PROTO_ICMP) begin
            repeat (8) frame_buf.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 12)) frame_buf.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 4)) frame_buf.push_back(8'($urandom));

        if (keep > 0) begin
            while (frame_buf.size() > keep) void'(frame_buf.pop_back());
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset settings: Ethernet with VLAN detection, checksum checking on.
    task automatic test_reset_settings();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 0);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_UDP, 1'b1, 0);
        send_frame();
        build_frame(MODE_ETH, LINK_VLAN, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 0);
        send_frame();
        // A complete ICMP packet and an unknown protocol stay undefined.
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_ICMP, 1'b1, 0);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, 8'd47, 1'b1, 0);
        send_frame();
        build_frame(MODE_ETH, LINK_OTHER, IPV4_VERSION, IPV4_IHL, PROTO_UDP, 1'b1, 0);
        send_frame();
    endtask

    // Frames cut off inside the link header, the IP header and each
    // layer-four header. Missing type bytes read as zero.
    task automatic test_truncation();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 1);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 12);
        send_frame();
        // Only the high type byte arrives: 0x81 followed by a missing zero
        // still reads as VLAN.
        build_frame(MODE_ETH, LINK_VLAN, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 13);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 30);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 44);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_UDP, 1'b1, 39);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_ICMP, 1'b1, 38);
        send_frame();
    endtask

    // IP header faults and byte extremes.
    task automatic test_header_faults();
        int i;
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, 4'd6, PROTO_TCP, 1'b1, 0);
        send_frame();
        // With a zero IHL the layer-four fields are taken from the IP header.
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, 4'd0, PROTO_UDP, 1'b1, 0);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, 4'd6, IPV4_IHL, PROTO_UDP, 1'b1, 0);
        send_frame();
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_UDP, 1'b0, 0);
        send_frame();
        for (i = 0; i < 2; i++) begin
            frame_buf.delete();
            repeat (40) frame_buf.push_back(i == 0 ? 8'hFF : 8'h00);
            send_frame();
        end
    endtask

    // Every link mode, including the raw non-IP setting, and checksum off.
    task automatic test_link_modes();
        write_reg(REG_LINK_MODE, MODE_NONE);
        build_frame(MODE_NONE, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 0);
        send_frame();
        write_reg(REG_LINK_MODE, MODE_SHORT);
        build_frame(MODE_SHORT, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_UDP, 1'b1, 0);
        send_frame();
        build_frame(MODE_SHORT, LINK_OTHER, IPV4_VERSION, IPV4_IHL, PROTO_UDP, 1'b1, 0);
        send_frame();
        build_frame(MODE_SHORT, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_UDP, 1'b1, 3);
        send_frame();
        write_reg(REG_LINK_MODE, MODE_RAW);
        build_frame(MODE_RAW, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b1, 0);
        send_frame();
        write_reg(REG_CSUM_EN, 1'b0);
        write_reg(REG_LINK_MODE, MODE_ETH);
        build_frame(MODE_ETH, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_TCP, 1'b0, 0);
        send_frame();
        write_reg(REG_CSUM_EN, 1'b1);
    endtask

    // One frame long enough to saturate the byte position counter, sent
    // without gaps to keep the run short.
    task automatic test_long_frame();
        write_reg(REG_LINK_MODE, MODE_NONE);
        build_frame(MODE_NONE, LINK_IP, IPV4_VERSION, IPV4_IHL, PROTO_UDP, 1'b1, 0);
        while (frame_buf.size() < POS_MAX + 3) frame_buf.push_back(8'($urandom));
        gaps_allowed = 1'b0;
        send_frame();
        gaps_allowed = 1'b1;
        drain();
    endtask

    // Mostly well-formed frames with random content under random settings;
    // the rest are truncated, corrupted or pure noise.
    task automatic test_random_traffic();
        int          nframes;
        int          pick;
        int          link_kind;
        int          keep;
        logic [7:0]  proto;
        logic [3:0]  ver;
        logic [3:0]  ihl;
        bit          csum_ok;
        nframes = 0;
        while (random_bytes_sent < RANDOM_BYTES || nframes < RANDOM_FRAMES) begin
            if (nframes % 10 == 0) begin
                write_reg(REG_LINK_MODE, 2'($urandom_range(0, 3)));
                write_reg(REG_CSUM_EN, 1'($urandom_range(0, 1)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                frame_buf.delete();
                repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40)      proto = PROTO_TCP;
                else if (pick < 70) proto = PROTO_UDP;
                else if (pick < 85) proto = PROTO_ICMP;
                else                proto = 8'($urandom);
                pick = $urandom_range(0, 9);
                link_kind = (pick == 0) ? LINK_OTHER : (pick < 4) ? LINK_VLAN : LINK_IP;
                ver  = ($urandom_range(0, 19) == 0) ? 4'($urandom) : IPV4_VERSION;
                ihl  = ($urandom_range(0, 19) == 0) ? 4'($urandom) : IPV4_IHL;
                csum_ok = ($urandom_range(0, 9) != 0);
                keep = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 60) : 0;
                build_frame(mode_cfg, link_kind, ver, ihl, proto, csum_ok, keep);
                if ($urandom_range(0, 19) == 0)
                    frame_buf[$urandom_range(0, frame_buf.size() - 1)] ^= 8'($urandom_range(1, 255));
            end
            random_bytes_sent += frame_buf.size();
            send_frame();
            nframes++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, run the tests, drain and report.
    // ------------------------------------------------------------------------
    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_LINK_MODE;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        mode_cfg    = LINK_MODE_RST;
        csum_cfg    = CSUM_EN_RST;
        clear_parse_state();
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_settings();
        test_truncation();
        test_header_faults();
        test_link_modes();
        test_long_frame();
        test_random_traffic();

        // The result register is loaded in the cycle after the last byte is taken.
        drain();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
